FILE: hdl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and constants of the indexed sequential list: item layout,
// action and status codes, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package isl_pkg;

  // item field widths
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned IN_W    = 48;
  localparam int unsigned OUT_W   = 56;

  // action codes, code seven is unused and rejected
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_READ   = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_PREV   = 3'd4,
    ACT_NEXT   = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_REJECT    = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_GRAB,
    S_DEL_SHIFT,
    S_RD_GRAB,
    S_SCAN,
    S_NEXT_GRAB,
    S_FINISH
  } state_e;

  // pointer update
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_POS,
    PTR_LAST,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  // memory write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_PUT
  } wr_op_e;

  // length counter update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  // result data update
  typedef enum logic [1:0] {
    DATA_HOLD,
    DATA_RD,
    DATA_PREV
  } data_op_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_in;
    ptr_op_e  ptr_op;
    wr_op_e   wr_op;
    cnt_op_e  cnt_op;
    logic     st_ld;
    status_e  st_val;
    data_op_e data_op;
    logic     idx_ld;
    logic     out_ld;
  } isl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    action_e act;
    logic    full;
    logic    pos_gt_cnt;
    logic    pos_ge_cnt;
    logic    pos_eq_cnt;
    logic    cnt_zero;
    logic    ptr_gt_pos;
    logic    ptr_last;
    logic    ptr_zero;
    logic    hit;
    logic    out_free;
  } isl_stat_t;

endpackage

FILE: hdl/isl_ram.sv
// ----------------------------------------------------------------------------
// isl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/isl_ctrl.sv
// ----------------------------------------------------------------------------
// isl_ctrl
// Controller of the indexed sequential list: decodes the action of the item
// held in the datapath and steps it through shift, grab and scan states.
// ----------------------------------------------------------------------------
module isl_ctrl
  import isl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  isl_stat_t stat_i,
  output isl_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   loc_hit, prev_hit, next_hit;

  // scan hits qualified by the action
  assign loc_hit  = (stat_i.act == ACT_LOCATE) && stat_i.hit;
  assign prev_hit = (stat_i.act == ACT_PREV) && stat_i.hit && !stat_i.ptr_zero;
  assign next_hit = (stat_i.act == ACT_NEXT) && stat_i.hit && !stat_i.ptr_last;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.act)
          ACT_INSERT: begin
            if (stat_i.full || stat_i.pos_gt_cnt) state_d = S_FINISH;
            else if (stat_i.pos_eq_cnt)           state_d = S_INS_PUT;
            else                                  state_d = S_INS_SHIFT;
          end
          ACT_DELETE: state_d = stat_i.pos_ge_cnt ? S_FINISH : S_DEL_GRAB;
          ACT_READ:   state_d = stat_i.pos_ge_cnt ? S_FINISH : S_RD_GRAB;
          ACT_LOCATE, ACT_PREV, ACT_NEXT: begin
            state_d = stat_i.cnt_zero ? S_FINISH : S_SCAN;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_INS_SHIFT: begin
        if (!stat_i.ptr_gt_pos) state_d = S_INS_PUT;
      end
      S_INS_PUT: state_d = S_FINISH;
      S_DEL_GRAB: state_d = stat_i.ptr_last ? S_FINISH : S_DEL_SHIFT;
      S_DEL_SHIFT: begin
        if (stat_i.ptr_last) state_d = S_FINISH;
      end
      S_RD_GRAB: state_d = S_FINISH;
      S_SCAN: begin
        if (loc_hit || prev_hit)  state_d = S_FINISH;
        else if (next_hit)        state_d = S_NEXT_GRAB;
        else if (stat_i.ptr_last) state_d = S_FINISH;
      end
      S_NEXT_GRAB: state_d = S_FINISH;
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.ptr_op  = PTR_HOLD;
    cmd_o.wr_op   = WR_NONE;
    cmd_o.cnt_op  = CNT_HOLD;
    cmd_o.st_val  = ST_OK;
    cmd_o.data_op = DATA_HOLD;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_DECODE: begin
        case (stat_i.act)
          ACT_INSERT: begin
            if (stat_i.full || stat_i.pos_gt_cnt) begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = ST_REJECT;
            end else if (!stat_i.pos_eq_cnt) begin
              cmd_o.ptr_op = PTR_LAST;
            end
          end
          ACT_DELETE, ACT_READ: begin
            if (stat_i.pos_ge_cnt) begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = ST_REJECT;
            end else begin
              cmd_o.ptr_op = PTR_POS;
            end
          end
          ACT_LOCATE, ACT_PREV, ACT_NEXT: begin
            if (stat_i.cnt_zero) begin
              cmd_o.st_ld  = 1'b1;
              cmd_o.st_val = ST_NOT_FOUND;
            end else begin
              cmd_o.ptr_op = PTR_ZERO;
            end
          end
          ACT_CLEAR: cmd_o.cnt_op = CNT_CLR;
          default: begin
            cmd_o.st_ld  = 1'b1;
            cmd_o.st_val = ST_REJECT;
          end
        endcase
      end
      S_INS_SHIFT: begin
        cmd_o.wr_op = WR_UP;
        if (stat_i.ptr_gt_pos) cmd_o.ptr_op = PTR_DEC;
      end
      S_INS_PUT: begin
        cmd_o.wr_op  = WR_PUT;
        cmd_o.cnt_op = CNT_INC;
      end
      S_DEL_GRAB: begin
        cmd_o.data_op = DATA_RD;
        if (stat_i.ptr_last) cmd_o.cnt_op = CNT_DEC;
        else                 cmd_o.ptr_op = PTR_INC;
      end
      S_DEL_SHIFT: begin
        cmd_o.wr_op = WR_DOWN;
        if (stat_i.ptr_last) cmd_o.cnt_op = CNT_DEC;
        else                 cmd_o.ptr_op = PTR_INC;
      end
      S_RD_GRAB: cmd_o.data_op = DATA_RD;
      S_SCAN: begin
        if (loc_hit) begin
          cmd_o.idx_ld = 1'b1;
        end else if (prev_hit) begin
          cmd_o.data_op = DATA_PREV;
        end else if (next_hit) begin
          cmd_o.ptr_op = PTR_INC;
        end else if (stat_i.ptr_last) begin
          cmd_o.st_ld  = 1'b1;
          cmd_o.st_val = ST_NOT_FOUND;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_NEXT_GRAB: cmd_o.data_op = DATA_RD;
      S_FINISH: cmd_o.out_ld = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/isl_dp.sv
// ----------------------------------------------------------------------------
// isl_dp
// Datapath of the indexed sequential list: item registers, length counter,
// walking pointer, entry memory, result registers and the output register.
// ----------------------------------------------------------------------------
module isl_dp
  import isl_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isl_cmd_t         cmd_i,
  output isl_stat_t        stat_o,
  input  logic [IN_W-1:0]  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // item registers
  logic [ACT_W-1:0] act_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;

  // control state
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             out_valid_q;

  // result and scan registers
  logic [ST_W-1:0]  res_st_q;
  logic [VAL_W-1:0] res_data_q;
  logic [IDX_W-1:0] res_idx_q;
  logic [VAL_W-1:0] prev_q;
  logic [OUT_W-1:0] out_data_q;

  logic [CMPW-1:0]  pos_x, cnt_x, ptr_x;
  logic [CW-1:0]    ptr_inc, ptr_dec;
  logic [VAL_W-1:0] rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [CNT_W-1:0] cnt_out;

  assign pos_x   = CMPW'(pos_q);
  assign cnt_x   = CMPW'(cnt_q);
  assign ptr_x   = CMPW'(ptr_q);
  assign ptr_inc = ptr_q + CW'(1);
  assign ptr_dec = ptr_q - CW'(1);

  // capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q <= in_data_i[ACT_W-1:0];
      pos_q <= in_data_i[ACT_W +: POS_W];
      val_q <= in_data_i[ACT_W+POS_W +: VAL_W];
    end
  end

  // pointer, read address follows its next value
  always_comb begin
    case (cmd_i.ptr_op)
      PTR_ZERO: ptr_d = '0;
      PTR_POS:  ptr_d = pos_x[CW-1:0];
      PTR_LAST: ptr_d = cnt_q - CW'(1);
      PTR_INC:  ptr_d = ptr_inc;
      PTR_DEC:  ptr_d = ptr_dec;
      default:  ptr_d = ptr_q;
    endcase
  end

  // length counter
  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  // write side: shift up, shift down or place the new value
  always_comb begin
    we    = 1'b1;
    waddr = pos_x[AW-1:0];
    wdata = rdata;
    case (cmd_i.wr_op)
      WR_UP:   waddr = ptr_inc[AW-1:0];
      WR_DOWN: waddr = ptr_dec[AW-1:0];
      WR_PUT:  wdata = val_q;
      default: we = 1'b0;
    endcase
  end

  isl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_d[AW-1:0]),
    .rdata_o (rdata)
  );

  // result registers, cleared for each new item
  always_ff @(posedge clk_i) begin
    prev_q <= rdata;
    if (cmd_i.load_in) begin
      res_st_q   <= ST_OK;
      res_data_q <= '0;
      res_idx_q  <= '0;
    end else begin
      if (cmd_i.st_ld) res_st_q <= cmd_i.st_val;
      case (cmd_i.data_op)
        DATA_RD:   res_data_q <= rdata;
        DATA_PREV: res_data_q <= prev_q;
        default:   res_data_q <= res_data_q;
      endcase
      if (cmd_i.idx_ld) res_idx_q <= ptr_x[IDX_W-1:0];
    end
  end

  // output register
  assign cnt_out = cnt_x[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_data_q <= {7'd0,
                     (cnt_q == CW'(DEPTH)),
                     (cnt_q == '0),
                     cnt_out,
                     res_idx_q,
                     res_data_q,
                     res_st_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status toward the controller
  always_comb begin
    stat_o            = '0;
    stat_o.act        = action_e'(act_q);
    stat_o.full       = (cnt_q == CW'(DEPTH));
    stat_o.pos_gt_cnt = (pos_x > cnt_x);
    stat_o.pos_ge_cnt = (pos_x >= cnt_x);
    stat_o.pos_eq_cnt = (pos_x == cnt_x);
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.ptr_gt_pos = (ptr_x > pos_x);
    stat_o.ptr_last   = (ptr_inc == cnt_q);
    stat_o.ptr_zero   = (ptr_q == '0);
    stat_o.hit        = (rdata == val_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

FILE: hdl/indexed_sequential_list.sv
// ----------------------------------------------------------------------------
// indexed_sequential_list
// Ordered list of signed 32-bit values with insert, delete, read, search and
// clear at an index, one status result for each item.
// ----------------------------------------------------------------------------
// One item is worked at a time; the slave side is ready only while the block
// is idle, and a finished result waits in the output register without
// holding up the next item. All entries live in one RAM with one write and
// one registered read port, so shift and search steps go one entry at a time.
// Insert moves the entries from the tail down to the position up by one,
// delete moves those above the position down by one, and locate, previous
// and next examine entries from the head, at most count of them, with one
// more read of the successor for a next hit. Another item may be accepted in
// the cycle after a result loads.
// ----------------------------------------------------------------------------
module indexed_sequential_list
  import isl_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // action [2:0], position [9:3], value [41:10], zero [47:42]
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // status [1:0], data_out [33:2], found_index [39:34], count [46:40],
  // is_empty [47], is_full [48], zero [55:49]
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i
);

  isl_cmd_t  cmd;
  isl_stat_t stat;

  // sequencer
  isl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, counters and result path
  isl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed sequential list. A directed table walks
// the empty-list and out-of-range cases, mostly with hand-typed results; a
// fill to the top then checks an insert into a full list. Random traffic
// follows, grouped in grow, shrink and mixed phases. Every item accepted on
// the slave side steps a local shadow of the list, and each item leaving the
// master side is compared field by field with the oldest prediction. Both
// sides idle in random bursts. The receiver also holds off once for a long
// stretch so that the block backs up onto its input.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import isl_pkg::*;

  localparam int unsigned LIST_DEPTH   = 64;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned QUIET_TAIL   = 150;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PLAN_ROWS    = 25;

  // action code seven is not decoded and must be rejected
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX    = 32'h7fff_ffff;

  // one result item, unpacked from the master side
  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  data;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
    logic              empty;
    logic              full;
  } list_result_t;

  // directed row: result is typed in only where typed is set
  typedef struct {
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    bit               typed;
    status_e          st;
    logic [VAL_W-1:0] data;
    logic [CNT_W-1:0] cnt;
  } plan_row_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;

  // shadow of the list contents and length
  logic [VAL_W-1:0] list_mem [LIST_DEPTH];
  int unsigned      list_len = 0;

  list_result_t     pending_results [$];
  int unsigned      mismatch_count   = 0;
  int unsigned      results_checked  = 0;
  int unsigned      items_accepted   = 0;
  int unsigned      act_tally [8]    = '{default: 0};
  int unsigned      full_seen        = 0;
  int unsigned      empty_seen       = 0;
  bit               quiet            = 1'b0;
  int unsigned      tx_gap_pct       = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ACT_READ,   7'd0,   32'd0,        1'b1, ST_REJECT,    32'd0, 7'd0},
    '{ACT_DELETE, 7'd0,   32'd0,        1'b1, ST_REJECT,    32'd0, 7'd0},
    '{ACT_LOCATE, 7'd0,   32'd5,        1'b1, ST_NOT_FOUND, 32'd0, 7'd0},
    '{ACT_PREV,   7'd0,   32'd5,        1'b1, ST_NOT_FOUND, 32'd0, 7'd0},
    '{ACT_NEXT,   7'd0,   32'd5,        1'b1, ST_NOT_FOUND, 32'd0, 7'd0},
    '{ACT_INSERT, 7'd1,   32'd7,        1'b1, ST_REJECT,    32'd0, 7'd0},
    '{ACT_INSERT, 7'd0,   VAL_MIN,      1'b1, ST_OK,        32'd0, 7'd1},
    '{ACT_INSERT, 7'd1,   VAL_MAX,      1'b1, ST_OK,        32'd0, 7'd2},
    '{ACT_INSERT, 7'd1,   32'd0,        1'b0, ST_OK,        32'd0, 7'd0},
    '{ACT_INSERT, 7'd127, 32'd9,        1'b1, ST_REJECT,    32'd0, 7'd3},
    '{ACT_INSERT, 7'd64,  32'd9,        1'b1, ST_REJECT,    32'd0, 7'd3},
    '{ACT_READ,   7'd2,   32'd0,        1'b0, ST_OK,        32'd0, 7'd0},
    '{ACT_READ,   7'd3,   32'd0,        1'b1, ST_REJECT,    32'd0, 7'd3},
    '{ACT_READ,   7'd127, 32'hffff_ffff, 1'b1, ST_REJECT,   32'd0, 7'd3},
    '{ACT_LOCATE, 7'd0,   VAL_MAX,      1'b0, ST_OK,        32'd0, 7'd0},
    '{ACT_PREV,   7'd0,   VAL_MIN,      1'b1, ST_NOT_FOUND, 32'd0, 7'd3},
    '{ACT_NEXT,   7'd0,   VAL_MAX,      1'b1, ST_NOT_FOUND, 32'd0, 7'd3},
    '{ACT_PREV,   7'd0,   32'd0,        1'b0, ST_OK,        32'd0, 7'd0},
    '{ACT_NEXT,   7'd0,   32'd0,        1'b0, ST_OK,        32'd0, 7'd0},
    '{ACT_UNUSED, 7'd5,   32'd0,        1'b1, ST_REJECT,    32'd0, 7'd3},
    '{ACT_DELETE, 7'd1,   32'd0,        1'b0, ST_OK,        32'd0, 7'd0},
    '{ACT_DELETE, 7'd2,   32'd0,        1'b1, ST_REJECT,    32'd0, 7'd2},
    '{ACT_CLEAR,  7'd0,   32'd0,        1'b1, ST_OK,        32'd0, 7'd0},
    '{ACT_INSERT, 7'd0,   32'hffff_ffff, 1'b0, ST_OK,       32'd0, 7'd0},
    '{ACT_DELETE, 7'd0,   32'd0,        1'b0, ST_OK,        32'd0, 7'd0}
  };

  indexed_sequential_list #(
    .DEPTH (LIST_DEPTH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // steps the shadow list by one action and returns the expected result
  function automatic list_result_t apply_action(input logic [ACT_W-1:0] act,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] key);
    list_result_t res;
    int unsigned  j;
    bit           hit;
    res        = '0;
    res.status = ST_OK;
    hit        = 1'b0;
    case (act)
      ACT_INSERT: begin
        if (list_len >= LIST_DEPTH || pos > list_len) begin
          res.status = ST_REJECT;
        end else begin
          for (j = list_len; j > pos; j--) list_mem[j] = list_mem[j-1];
          list_mem[pos] = key;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= list_len) begin
          res.status = ST_REJECT;
        end else begin
          res.data = list_mem[pos];
          for (j = pos; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
          list_len--;
        end
      end
      ACT_READ: begin
        if (pos >= list_len) res.status = ST_REJECT;
        else res.data = list_mem[pos];
      end
      ACT_LOCATE: begin
        for (j = 0; j < list_len && !hit; j++) begin
          if (list_mem[j] == key) begin
            res.idx = 6'(j);
            hit     = 1'b1;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      ACT_PREV: begin
        // a match at the head has no predecessor
        for (j = 1; j < list_len && !hit; j++) begin
          if (list_mem[j] == key) begin
            res.data = list_mem[j-1];
            hit      = 1'b1;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      ACT_NEXT: begin
        // a match at the tail has no successor
        for (j = 0; j + 1 < list_len && !hit; j++) begin
          if (list_mem[j] == key) begin
            res.data = list_mem[j+1];
            hit      = 1'b1;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
        res.status = ST_REJECT;
      end
    endcase
    res.count = 7'(list_len);
    res.empty = (list_len == 0);
    res.full  = (list_len == LIST_DEPTH);
    return res;
  endfunction

  // offers one item on the slave side and records its prediction on accept
  task automatic offer_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] key, input bit typed,
                            input list_result_t want);
    list_result_t predicted;
    int unsigned  gap;
    // random idle burst before the item
    if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, key, pos, act};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predicted = apply_action(act, pos, key);
    pending_results.push_back(typed ? want : predicted);
    items_accepted++;
    act_tally[act]++;
    if (predicted.full) full_seen++;
    if (predicted.empty) empty_seen++;
  endtask

  // result checker on the master side
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.status = status_e'(m_axis_tdata[1:0]);
      got.data   = m_axis_tdata[33:2];
      got.idx    = m_axis_tdata[39:34];
      got.count  = m_axis_tdata[46:40];
      got.empty  = m_axis_tdata[47];
      got.full   = m_axis_tdata[48];
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.data !== want.data) begin
          $error("data_out expected %h got %h", want.data, got.data);
          mismatch_count++;
        end
        if (got.idx !== want.idx) begin
          $error("found_index expected %0d got %0d", want.idx, got.idx);
          mismatch_count++;
        end
        if (got.count !== want.count) begin
          $error("count expected %0d got %0d", want.count, got.count);
          mismatch_count++;
        end
        if (got.empty !== want.empty) begin
          $error("is_empty expected %0b got %0b", want.empty, got.empty);
          mismatch_count++;
        end
        if (got.full !== want.full) begin
          $error("is_full expected %0b got %0b", want.full, got.full);
          mismatch_count++;
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    int unsigned rx_stall_pct;
    int unsigned cycle_cnt;
    bit          hold_done;
    hold_left    = 0;
    burst_left   = 0;
    rx_stall_pct = 0;
    cycle_cnt    = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk_i);
      cycle_cnt++;
      // stall rate changes now and then, zero included
      if (cycle_cnt % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 10;
          default: rx_stall_pct = 30;
        endcase
      end
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        m_axis_tready <= 1'b0;
        burst_left--;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready <= 1'b0;
        burst_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus: directed table, full-list fill, then random phases
  initial begin
    list_result_t     want;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] key;
    int unsigned      ins_pct;
    int unsigned      del_pct;
    int unsigned      pick;
    int unsigned      n;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    tx_gap_pct = 20;
    for (n = 0; n < PLAN_ROWS; n++) begin
      want        = '0;
      want.status = plan[n].st;
      want.data   = plan[n].data;
      want.count  = plan[n].cnt;
      want.empty  = (plan[n].cnt == 0);
      want.full   = (plan[n].cnt == LIST_DEPTH);
      offer_item(plan[n].act, plan[n].pos, plan[n].val, plan[n].typed, want);
    end

    // fill to the top, then an insert into a full list is rejected
    for (n = 0; n < LIST_DEPTH; n++) offer_item(ACT_INSERT, 7'(n), $urandom(), 1'b0, '0);
    want        = '0;
    want.status = ST_REJECT;
    want.count  = 7'(LIST_DEPTH);
    want.full   = 1'b1;
    offer_item(ACT_INSERT, 7'd0, 32'd1, 1'b1, want);

    // random phases
    ins_pct = 35;
    del_pct = 30;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - QUIET_TAIL);
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: begin ins_pct = 65; del_pct = 15; end
          1: begin ins_pct = 15; del_pct = 60; end
          default: begin ins_pct = 35; del_pct = 30; end
        endcase
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 15;
          default: tx_gap_pct = 40;
        endcase
      end

      // action
      pick = $urandom_range(0, 99);
      if (pick < ins_pct) begin
        act = ACT_INSERT;
      end else if (pick < ins_pct + del_pct) begin
        act = ACT_DELETE;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) act = ACT_CLEAR;
        else if (pick < 3) act = ACT_UNUSED;
        else if (pick < 28) act = ACT_READ;
        else if (pick < 52) act = ACT_LOCATE;
        else if (pick < 76) act = ACT_PREV;
        else act = ACT_NEXT;
      end

      // position: mostly legal, sometimes anything the field holds
      if ($urandom_range(0, 9) == 0 || !(act inside {ACT_INSERT, ACT_DELETE, ACT_READ})) begin
        pos = 7'($urandom_range(0, 127));
      end else if (act == ACT_INSERT) begin
        pos = 7'($urandom_range(0, list_len));
      end else begin
        pos = (list_len == 0) ? 7'd0 : 7'($urandom_range(0, list_len - 1));
      end

      // value: stored keys for searches, a small pool for duplicates
      pick = $urandom_range(0, 9);
      if (act inside {ACT_LOCATE, ACT_PREV, ACT_NEXT} && list_len > 0 && pick < 6) begin
        key = list_mem[$urandom_range(0, list_len - 1)];
      end else if (pick < 8) begin
        key = 32'(int'($urandom_range(0, 7)) - 4);
      end else begin
        key = $urandom();
      end

      offer_item(act, pos, key, 1'b0, '0);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // wait for the last results, then let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d items: insert %0d delete %0d read %0d locate %0d prev %0d next %0d",
             items_accepted, act_tally[ACT_INSERT], act_tally[ACT_DELETE],
             act_tally[ACT_READ], act_tally[ACT_LOCATE], act_tally[ACT_PREV],
             act_tally[ACT_NEXT]);
    $display("clear %0d, unused code %0d, list full after %0d items, empty after %0d, %0d checked",
             act_tally[ACT_CLEAR], act_tally[ACT_UNUSED], full_seen, empty_seen,
             results_checked);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: indexed_sequential_list.f
hdl/isl_pkg.sv
hdl/isl_ram.sv
hdl/isl_ctrl.sv
hdl/isl_dp.sv
hdl/indexed_sequential_list.sv
verif/testbench.sv
